// ===== hw/rtl/olisr_pkg.sv =====
// ----------------------------------------------------------------------------
// olisr_pkg: shared types and constants of the ordered list
// Sizes, operation and status codes, cell command and control state types.
// ----------------------------------------------------------------------------
package olisr_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int STAT_W   = 2;

    // request operation codes
    localparam logic [FUNC_W-1:0] OP_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t                 op;
        logic [IDX_W-1:0]         idx;
        logic signed [VAL_W-1:0]  val;
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // Index of the lowest set bit, found by halving the window each step.
    function automatic logic [IDX_W-1:0] find_first(input logic [CAPACITY-1:0] v);
        logic [CAPACITY-1:0] w;
        logic [CAPACITY-1:0] lo_mask;
        logic [IDX_W-1:0]    idx;
        w   = v;
        idx = '0;
        for (int b = IDX_W - 1; b >= 0; b--) begin
            lo_mask = {CAPACITY{1'b1}} >> (CAPACITY - (1 << b));
            if ((w & lo_mask) == '0) begin
                idx[b] = 1'b1;
                w      = w >> (1 << b);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/olisr_cell.sv =====
// ----------------------------------------------------------------------------
// olisr_cell: one storage cell of the list chain
// Holds one entry, compares it with the broadcast value, and takes data
// from the left or right neighbor on insert or remove.
// ----------------------------------------------------------------------------
module olisr_cell (
    input  logic                                aclk,
    input  logic [olisr_pkg::IDX_W-1:0]         my_index,
    input  logic signed [olisr_pkg::VAL_W-1:0]  left_entry,
    input  logic signed [olisr_pkg::VAL_W-1:0]  right_entry,
    input  logic signed [olisr_pkg::VAL_W-1:0]  cmp_val,
    input  olisr_pkg::cell_cmd_t                cmd,
    output logic signed [olisr_pkg::VAL_W-1:0]  entry,
    output logic                                match
);

    logic signed [olisr_pkg::VAL_W-1:0] entry_reg;
    logic signed [olisr_pkg::VAL_W-1:0] entry_next;
    logic                               match_reg;

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            olisr_pkg::CELL_WRITE: begin
                if (my_index == cmd.idx) begin
                    entry_next = cmd.val;
                end
            end
            olisr_pkg::CELL_INSERT: begin
                if (my_index == cmd.idx) begin
                    entry_next = cmd.val;
                end else if (my_index > cmd.idx) begin
                    entry_next = left_entry;
                end
            end
            olisr_pkg::CELL_REMOVE: begin
                if (my_index >= cmd.idx) begin
                    entry_next = right_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        match_reg <= (entry_reg == cmp_val);
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// ===== hw/rtl/ordered_list_insert_search_remove.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_search_remove: fixed-capacity ordered list
// A chain of 64 cells holding signed 32-bit entries, with append, insert,
// search and remove requests and one status result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: valid/ready, one request per handshake carrying
//   s_func (append, insert, search, remove), s_position (insert only) and
//   s_item_value. Result channel m_*: valid/ready, one result per request
//   with m_status, m_found_index and m_entry_count (count after request).
// Sequence:
//   Each request runs as follows: in the accept cycle every cell compares its
//   entry with the request value and registers a match bit; in the exec
//   state a priority encoder over the 64 match bits finds the first hit
//   and, once the result register is free, the whole chain shifts in
//   parallel and the result register loads. A new request is accepted only
//   after that compare-then-shift sequence has finished.
// Reset:
//   aresetn (synchronous, active low) empties the list and drops any result.
//   Entry contents are not cleared; slots past the count are never read.
// Back-pressure:
//   The result register holds while m_ready is low; a new request is still
//   accepted, and its update waits until the result register frees up.
// ----------------------------------------------------------------------------
module ordered_list_insert_search_remove (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [olisr_pkg::FUNC_W-1:0]        s_func,
    input  logic [olisr_pkg::CNT_W-1:0]         s_position,
    input  logic signed [olisr_pkg::VAL_W-1:0]  s_item_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [olisr_pkg::STAT_W-1:0]        m_status,
    output logic [olisr_pkg::IDX_W-1:0]         m_found_index,
    output logic [olisr_pkg::CNT_W-1:0]         m_entry_count
);

    localparam int CAP = olisr_pkg::CAPACITY;

    // control state
    olisr_pkg::ctrl_state_t state_reg, state_next;
    logic [olisr_pkg::CNT_W-1:0] count_reg, count_next;
    logic                        m_valid_reg, m_valid_next;

    // held request
    logic [olisr_pkg::FUNC_W-1:0]        req_func_reg;
    logic [olisr_pkg::CNT_W-1:0]         req_pos_reg;
    logic signed [olisr_pkg::VAL_W-1:0]  req_val_reg;

    // result register
    logic [olisr_pkg::STAT_W-1:0] status_reg, status_next;
    logic [olisr_pkg::IDX_W-1:0]  found_reg, found_next;

    // chain wiring
    logic signed [olisr_pkg::VAL_W-1:0] ent [CAP];
    logic [CAP-1:0]                     match_vec;
    logic [CAP-1:0]                     hit_vec;
    logic signed [olisr_pkg::VAL_W-1:0] cmp_val;
    olisr_pkg::cell_cmd_t               cmd;

    logic                        accept;
    logic                        out_free;
    logic                        full;
    logic                        any_hit;
    logic [olisr_pkg::IDX_W-1:0] first_hit;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == olisr_pkg::CNT_W'(CAP));

    // compare against the incoming value while idle, the held one after
    assign cmp_val = (state_reg == olisr_pkg::ST_IDLE) ? s_item_value : req_val_reg;

    // the cell chain; end cells see themselves past the edge
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        logic signed [olisr_pkg::VAL_W-1:0] left_w;
        logic signed [olisr_pkg::VAL_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = ent[i];
        end else begin : g_mid_l
            assign left_w = ent[i-1];
        end
        if (i == CAP - 1) begin : g_last
            assign right_w = ent[i];
        end else begin : g_mid_r
            assign right_w = ent[i+1];
        end

        olisr_cell u_cell (
            .aclk        (aclk),
            .my_index    (olisr_pkg::IDX_W'(i)),
            .left_entry  (left_w),
            .right_entry (right_w),
            .cmp_val     (cmp_val),
            .cmd         (cmd),
            .entry       (ent[i]),
            .match       (match_vec[i])
        );

        // only entries below the count take part in a search
        assign hit_vec[i] = match_vec[i] && (olisr_pkg::CNT_W'(i) < count_reg);
    end

    assign any_hit   = |hit_vec;
    assign first_hit = olisr_pkg::find_first(hit_vec);

    // next state, cell command and result
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        cmd.op       = olisr_pkg::CELL_HOLD;
        cmd.idx      = '0;
        cmd.val      = req_val_reg;

        // drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            olisr_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = olisr_pkg::ST_EXEC;
                end
            end
            olisr_pkg::ST_EXEC: begin
                // hold the update until the result register is free
                if (out_free) begin
                    state_next   = olisr_pkg::ST_IDLE;
                    m_valid_next = 1'b1;
                    status_next  = olisr_pkg::STAT_OK;
                    found_next   = '0;
                    case (req_func_reg)
                        olisr_pkg::OP_APPEND: begin
                            if (full) begin
                                status_next = olisr_pkg::STAT_FULL;
                            end else begin
                                cmd.op     = olisr_pkg::CELL_WRITE;
                                cmd.idx    = count_reg[olisr_pkg::IDX_W-1:0];
                                count_next = count_reg + olisr_pkg::CNT_W'(1);
                            end
                        end
                        olisr_pkg::OP_INSERT: begin
                            if (req_pos_reg > count_reg) begin
                                status_next = olisr_pkg::STAT_BAD_POS;
                            end else if (full) begin
                                status_next = olisr_pkg::STAT_FULL;
                            end else begin
                                cmd.op     = olisr_pkg::CELL_INSERT;
                                cmd.idx    = req_pos_reg[olisr_pkg::IDX_W-1:0];
                                count_next = count_reg + olisr_pkg::CNT_W'(1);
                            end
                        end
                        default: begin
                            // search and remove
                            if (!any_hit) begin
                                status_next = olisr_pkg::STAT_MISSING;
                            end else begin
                                found_next = first_hit;
                                if (req_func_reg == olisr_pkg::OP_REMOVE) begin
                                    cmd.op     = olisr_pkg::CELL_REMOVE;
                                    cmd.idx    = first_hit;
                                    count_next = count_reg - olisr_pkg::CNT_W'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                state_next = olisr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= olisr_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_func_reg <= s_func;
            req_pos_reg  <= s_position;
            req_val_reg  <= s_item_value;
        end
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    assign s_ready       = (state_reg == olisr_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_found_index = found_reg;
    assign m_entry_count = count_reg;

endmodule

// ===== hw/rtl/olisr_checker.sv =====
// ----------------------------------------------------------------------------
// olisr_checker: port-level checks of the ordered list
// Watches the result channel and flags illegal results.
// ----------------------------------------------------------------------------
module olisr_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [olisr_pkg::STAT_W-1:0]  m_status,
    input  logic [olisr_pkg::IDX_W-1:0]   m_found_index,
    input  logic [olisr_pkg::CNT_W-1:0]   m_entry_count
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_found_index) && $stable(m_entry_count))
        else $error("stalled result changed");

    // count never exceeds capacity
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= olisr_pkg::CNT_W'(olisr_pkg::CAPACITY))
        else $error("entry count above capacity");

    // a full report comes only with a full list
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == olisr_pkg::STAT_FULL
            |-> m_entry_count == olisr_pkg::CNT_W'(olisr_pkg::CAPACITY))
        else $error("list full reported below capacity");

    // a miss reports index zero
    a_miss_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == olisr_pkg::STAT_MISSING |-> m_found_index == '0)
        else $error("missing value with nonzero index");

endmodule

bind ordered_list_insert_search_remove olisr_checker u_olisr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_found_index (m_found_index),
    .m_entry_count (m_entry_count)
);
